// ===== design/bank_allocator_core_defines.svh =====
// assertion helpers used by the rtl
`ifndef BANK_ALLOCATOR_CORE_DEFINES_SVH
`define BANK_ALLOCATOR_CORE_DEFINES_SVH

// clocked check, masked while reset is asserted
`define BNKA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked check that also holds during reset
`define BNKA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/bnka_pkg.sv =====
`default_nettype none
package bnka_pkg;

    localparam int NUM_BANKS_DEF = 8;
    localparam int DATA_W        = 32;
    localparam int BANK_W        = 3;
    localparam int ACTIVE_W      = 4;
    localparam int PADDR_W       = 3;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET   = 4'd8;
    localparam logic [DATA_W-1:0]   CAPACITY_RESET = 32'd65536;

    // register index as decoded from paddr[2]
    localparam logic REG_ACTIVE_BANKS  = 1'b0;
    localparam logic REG_BANK_CAPACITY = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] alloc_size;
        logic              parallel;
    } req_t;

    typedef struct packed {
        logic [BANK_W-1:0] chosen_bank;
        logic [DATA_W-1:0] start_offset;
        logic              over_capacity;
    } rsp_t;

    typedef struct packed {
        logic [ACTIVE_W-1:0] active_banks;
        logic [DATA_W-1:0]   bank_capacity;
    } cfg_t;

endpackage
`default_nettype wire

// ===== design/bnka_ram.sv =====
`default_nettype none
module bnka_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/bnka_cfg.sv =====
`default_nettype none
module bnka_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bnka_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [bnka_pkg::DATA_W-1:0]    pwdata,
    output logic      [bnka_pkg::DATA_W-1:0]    prdata,
    output logic                                pready,
    output bnka_pkg::cfg_t                      cfg
);
    import bnka_pkg::*;

    logic [ACTIVE_W-1:0] active_banks_reg;
    logic [DATA_W-1:0]   bank_capacity_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_banks_reg  <= ACTIVE_RESET;
            bank_capacity_reg <= CAPACITY_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_ACTIVE_BANKS:  active_banks_reg  <= pwdata[ACTIVE_W-1:0];
                REG_BANK_CAPACITY: bank_capacity_reg <= pwdata;
                default:           active_banks_reg  <= active_banks_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ACTIVE_BANKS:  prdata = {{(DATA_W-ACTIVE_W){1'b0}}, active_banks_reg};
            REG_BANK_CAPACITY: prdata = bank_capacity_reg;
            default:           prdata = '0;
        endcase
    end

    assign cfg.active_banks  = active_banks_reg;
    assign cfg.bank_capacity = bank_capacity_reg;

endmodule
`default_nettype wire

// ===== design/bank_allocator_core.sv =====
// bank allocator: each request beat carries a size and a parallel flag; the block scans the
// usage counters of the active banks (one counter memory read per cycle), picks the first bank
// the request fits in (or the least-used bank for parallel requests, or when nothing fits),
// answers with that bank, its old usage as the start offset and an over-capacity flag, and
// writes back the saturated new usage. One request is worked on at a time: the scan reads the
// counters of n banks through the single read port of the counter memory, where n is the
// active bank count after clamping to 1..NUM_BANKS, and a write-back state follows. The result
// sits in an output register, so the next request is taken while it waits. Counters read as
// zero after reset through per-bank valid flops, so no clearing pass is needed. Configuration
// is through an apb port: active_banks at 0x0, bank_capacity at 0x4; write only while idle.
`default_nettype none
`include "bank_allocator_core_defines.svh"
module bank_allocator_core #(
    parameter int NUM_BANKS = bnka_pkg::NUM_BANKS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // request channel
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire bnka_pkg::req_t                 s_data,
    // result channel
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output bnka_pkg::rsp_t                      m_data,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bnka_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [bnka_pkg::DATA_W-1:0]    pwdata,
    output logic      [bnka_pkg::DATA_W-1:0]    prdata,
    output logic                                pready
);
    import bnka_pkg::*;

    localparam int IDX_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int CNT_W = $clog2(NUM_BANKS + 1);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        WRITE
    } state_t;

    state_t state_reg;

    cfg_t cfg;

    // latched request
    logic [DATA_W-1:0] size_reg;
    logic              par_reg;
    logic [CNT_W-1:0]  n_reg;

    // scan bookkeeping
    logic [CNT_W-1:0]  issue_cnt_reg;
    logic              data_valid_reg;
    logic [IDX_W-1:0]  data_idx_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  fit_idx_reg;
    logic [DATA_W-1:0] fit_val_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [DATA_W-1:0] best_val_reg;

    // one flop per bank: counter has been written since reset
    logic [NUM_BANKS-1:0] written_reg;

    // output register
    logic m_valid_reg;
    rsp_t m_data_reg;

    logic              accept;
    logic              out_free;
    logic [CNT_W-1:0]  n_clamp;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] usage;
    logic              fits;
    logic              last_data;
    logic              wr_en;
    logic [IDX_W-1:0]  bank_idx;
    logic [DATA_W-1:0] prior_usage;
    logic [DATA_W:0]   sum_wide;
    logic [DATA_W-1:0] after;

    bnka_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // clamp the active bank count into 1..NUM_BANKS
    always_comb begin
        priority if (cfg.active_banks == '0) begin
            n_clamp = CNT_W'(1);
        end else if (32'(cfg.active_banks) > NUM_BANKS) begin
            n_clamp = CNT_W'(NUM_BANKS);
        end else begin
            n_clamp = CNT_W'(cfg.active_banks);
        end
    end

    assign s_ready  = (state_reg == IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // bank 0 is read in the accept cycle, the rest while scanning
    assign rd_en   = accept || ((state_reg == SCAN) && (issue_cnt_reg < n_reg));
    assign rd_addr = (state_reg == IDLE) ? '0 : issue_cnt_reg[IDX_W-1:0];

    // unwritten counters read as zero
    assign usage     = written_reg[data_idx_reg] ? ram_rdata : '0;
    assign fits      = ({1'b0, usage} + {1'b0, size_reg}) <= {1'b0, cfg.bank_capacity};
    assign last_data = data_valid_reg && (issue_cnt_reg == n_reg);

    // final choice and saturating update
    assign bank_idx    = (!par_reg && found_reg) ? fit_idx_reg : best_idx_reg;
    assign prior_usage = (!par_reg && found_reg) ? fit_val_reg : best_val_reg;
    assign sum_wide    = {1'b0, prior_usage} + {1'b0, size_reg};
    assign after       = sum_wide[DATA_W] ? '1 : sum_wide[DATA_W-1:0];
    assign wr_en       = (state_reg == WRITE) && out_free;

    bnka_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_BANKS),
        .AW    (IDX_W)
    ) u_usage_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (bank_idx),
        .wdata (after),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= IDLE;
            m_valid_reg    <= 1'b0;
            data_valid_reg <= 1'b0;
            issue_cnt_reg  <= '0;
            found_reg      <= 1'b0;
            written_reg    <= '0;
        end else begin
            // beat taken and no new result loaded behind it
            if (m_valid_reg && m_ready && !wr_en) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (accept) begin
                        size_reg       <= s_data.alloc_size;
                        par_reg        <= s_data.parallel;
                        n_reg          <= n_clamp;
                        issue_cnt_reg  <= CNT_W'(1);
                        data_valid_reg <= 1'b1;
                        data_idx_reg   <= '0;
                        found_reg      <= 1'b0;
                        state_reg      <= SCAN;
                    end
                end
                SCAN: begin
                    if (issue_cnt_reg < n_reg) begin
                        issue_cnt_reg  <= issue_cnt_reg + CNT_W'(1);
                        data_idx_reg   <= issue_cnt_reg[IDX_W-1:0];
                        data_valid_reg <= 1'b1;
                    end else begin
                        data_valid_reg <= 1'b0;
                    end
                    if (data_valid_reg) begin
                        // first bank with room
                        if (!found_reg && fits) begin
                            found_reg   <= 1'b1;
                            fit_idx_reg <= data_idx_reg;
                            fit_val_reg <= usage;
                        end
                        // least used, strict compare keeps the lowest index on ties
                        if ((data_idx_reg == '0) || (usage < best_val_reg)) begin
                            best_idx_reg <= data_idx_reg;
                            best_val_reg <= usage;
                        end
                    end
                    if (last_data) begin
                        state_reg <= WRITE;
                    end
                end
                WRITE: begin
                    if (out_free) begin
                        written_reg[bank_idx]    <= 1'b1;
                        m_valid_reg              <= 1'b1;
                        m_data_reg.chosen_bank   <= BANK_W'(bank_idx);
                        m_data_reg.start_offset  <= prior_usage;
                        m_data_reg.over_capacity <= after > cfg.bank_capacity;
                        state_reg                <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a request beat always starts a scan
    `BNKA_ASSERT(a_accept_scan, aclk, aresetn, accept |=> (state_reg == SCAN), "no scan")
    // the updated counter belongs to an active bank
    `BNKA_ASSERT(a_bank_active, aclk, aresetn, wr_en |-> (CNT_W'(bank_idx) < n_reg), "bad bank")
    // every result beat follows a counter write-back
    `BNKA_ASSERT(a_result_after_write, aclk, aresetn, $rose(m_valid_reg) |-> $past(wr_en), "no wb")

endmodule
`default_nettype wire
